FILE: sv/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants of the tag marker stripper
// Result item layout, character codes, link codes and default sizes.
// ----------------------------------------------------------------------------
package tms_pkg;

  // default sizes
  localparam int DEF_MAX_TAG_CHARS = 64;
  localparam int DEF_NUMBER_WIDTH  = 10;

  // fixed field widths of a result item
  localparam int FIELD_W = 10;
  localparam int LEN_W   = 7;
  localparam int KIND_W  = 3;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // result kinds
  localparam logic RESULT_LINK    = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  // link letter codes
  localparam logic [KIND_W-1:0] LINK_M = 3'd0;
  localparam logic [KIND_W-1:0] LINK_A = 3'd1;
  localparam logic [KIND_W-1:0] LINK_S = 3'd2;
  localparam logic [KIND_W-1:0] LINK_H = 3'd3;
  localparam logic [KIND_W-1:0] LINK_D = 3'd4;

  // configuration register indexes
  localparam logic CFG_SLASH_TRIM   = 1'b0;
  localparam logic CFG_GENDER_STRIP = 1'b1;

  // character codes
  localparam logic [7:0] CH_END      = 8'h00;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] CH_IDIOM    = 8'h69;
  localparam logic [7:0] CH_LINK_M   = 8'h6D;
  localparam logic [7:0] CH_LINK_A   = 8'h61;
  localparam logic [7:0] CH_LINK_S   = 8'h73;
  localparam logic [7:0] CH_LINK_H   = 8'h68;
  localparam logic [7:0] CH_LINK_D   = 8'h64;

  typedef struct packed {
    logic               slash_trim_enable;
    logic               gender_strip_enable;
  } tms_cfg_t;

  typedef struct packed {
    logic               result_kind;
    logic [KIND_W-1:0]  link_kind;
    logic [FIELD_W-1:0] link_first;
    logic [FIELD_W-1:0] link_second;
    logic [FIELD_W-1:0] link_third;
    logic [LEN_W-1:0]   kept_length;
    logic [FIELD_W-1:0] idiom_first;
    logic [FIELD_W-1:0] idiom_second;
    logic [FIELD_W-1:0] idiom_third;
    logic               final_flag;
  } tms_res_t;

  // up to two result items caused by one character
  typedef struct packed {
    logic [1:0] count;
    tms_res_t   first;
    tms_res_t   second;
  } tms_push_t;

endpackage

FILE: sv/tms_parse.sv
// ----------------------------------------------------------------------------
// tms_parse: character parser
// Holds the per-tag scan state and turns one character into up to two results.
// ----------------------------------------------------------------------------
module tms_parse #(
  parameter int MAX_TAG_CHARS = tms_pkg::DEF_MAX_TAG_CHARS,
  parameter int NUMBER_WIDTH  = tms_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  tms_pkg::tms_cfg_t   cfg,
  input  logic                accept,
  input  logic [7:0]          tag_char,
  output tms_pkg::tms_push_t  push
);

  localparam int NW = NUMBER_WIDTH;
  localparam int LW = tms_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_POS = LW'(MAX_TAG_CHARS);
  localparam logic [NW-1:0] NUM_MAX = {NW{1'b1}};

  localparam logic [2:0] M_PLAIN = 3'd0;
  localparam logic [2:0] M_OPEN  = 3'd1;
  localparam logic [2:0] M_I1    = 3'd2;
  localparam logic [2:0] M_I2    = 3'd3;
  localparam logic [2:0] M_I3    = 3'd4;
  localparam logic [2:0] M_L1    = 3'd5;
  localparam logic [2:0] M_L2    = 3'd6;
  localparam logic [2:0] M_L3    = 3'd7;

  function automatic logic [tms_pkg::FIELD_W-1:0] narrow(input logic [NW-1:0] v);
    logic [NW+tms_pkg::FIELD_W-1:0] w;
    w = {{tms_pkg::FIELD_W{1'b0}}, v};
    return w[tms_pkg::FIELD_W-1:0];
  endfunction

  logic [2:0]    mode, mode_next;
  logic [NW-1:0] accum, accum_next;
  logic          stopped, stopped_next;
  logic [NW-1:0] held_first, held_first_next;
  logic [NW-1:0] held_second, held_second_next;
  logic [2:0]    link_kind, link_kind_next;
  logic          cut_valid, cut_valid_next;
  logic [LW-1:0] cut_pos, cut_pos_next;
  logic [LW-1:0] char_pos, char_pos_next;
  logic [NW-1:0] idiom [3];
  logic [NW-1:0] idiom_next [3];

  logic          is_digit, is_lower, link_char;
  logic [2:0]    link_code;
  logic [NW+3:0] grown;
  logic [LW-1:0] kept;
  tms_pkg::tms_res_t link_res, sum_res;

  assign is_digit = (tag_char >= tms_pkg::CH_DIGIT_LO) && (tag_char <= tms_pkg::CH_DIGIT_HI);
  assign is_lower = (tag_char >= tms_pkg::CH_LOWER_LO) && (tag_char <= tms_pkg::CH_LOWER_HI);
  assign grown = ({4'b0, accum} << 3) + ({4'b0, accum} << 1)
               + {{NW{1'b0}}, tag_char[3:0]};

  always_comb begin
    link_char = 1'b1;
    link_code = tms_pkg::LINK_M;
    unique case (tag_char)
      tms_pkg::CH_LINK_M: link_code = tms_pkg::LINK_M;
      tms_pkg::CH_LINK_A: link_code = tms_pkg::LINK_A;
      tms_pkg::CH_LINK_S: link_code = tms_pkg::LINK_S;
      tms_pkg::CH_LINK_H: link_code = tms_pkg::LINK_H;
      tms_pkg::CH_LINK_D: link_code = tms_pkg::LINK_D;
      default:            link_char = 1'b0;
    endcase
  end

  always_comb begin
    mode_next        = mode;
    accum_next       = accum;
    stopped_next     = stopped;
    held_first_next  = held_first;
    held_second_next = held_second;
    link_kind_next   = link_kind;
    cut_valid_next   = cut_valid;
    cut_pos_next     = cut_pos;
    char_pos_next    = (char_pos < MAX_POS) ? char_pos + LW'(1) : char_pos;
    idiom_next       = idiom;
    push             = '0;

    // link item: numbers not yet reached stay zero
    link_res             = '0;
    link_res.result_kind = tms_pkg::RESULT_LINK;
    link_res.link_kind   = link_kind;
    unique case (mode)
      M_L1:    link_res.link_first = narrow(accum);
      M_L2: begin
        link_res.link_first  = narrow(held_first);
        link_res.link_second = narrow(accum);
      end
      default: begin
        link_res.link_first  = narrow(held_first);
        link_res.link_second = narrow(held_second);
        link_res.link_third  = narrow(accum);
      end
    endcase

    // summary item: an idiom number in progress is stored first
    kept = cut_valid ? cut_pos : char_pos;
    if (kept > MAX_POS) begin
      kept = MAX_POS;
    end
    sum_res              = '0;
    sum_res.result_kind  = tms_pkg::RESULT_SUMMARY;
    sum_res.kept_length  = kept;
    sum_res.idiom_first  = narrow((mode == M_I1) ? accum : idiom[0]);
    sum_res.idiom_second = narrow((mode == M_I2) ? accum : idiom[1]);
    sum_res.idiom_third  = narrow((mode == M_I3) ? accum : idiom[2]);
    sum_res.final_flag   = 1'b1;

    if (tag_char == tms_pkg::CH_END) begin
      // end of tag: flush an open link, emit summary, clear everything
      if (mode == M_L1 || mode == M_L2 || mode == M_L3) begin
        push.count  = 2'd2;
        push.first  = link_res;
        push.second = sum_res;
      end else begin
        push.count = 2'd1;
        push.first = sum_res;
      end
      mode_next        = M_PLAIN;
      accum_next       = '0;
      stopped_next     = 1'b0;
      held_first_next  = '0;
      held_second_next = '0;
      link_kind_next   = '0;
      cut_valid_next   = 1'b0;
      cut_pos_next     = '0;
      char_pos_next    = '0;
      idiom_next[0]    = '0;
      idiom_next[1]    = '0;
      idiom_next[2]    = '0;
    end else begin
      unique case (mode)
        M_PLAIN: begin
          if (tag_char == tms_pkg::CH_LBRACKET) begin
            mode_next = M_OPEN;
          end
          if (!cut_valid && (tag_char == tms_pkg::CH_LBRACKET
              || tag_char == tms_pkg::CH_LBRACE
              || (cfg.gender_strip_enable && is_lower)
              || (cfg.slash_trim_enable && tag_char == tms_pkg::CH_SLASH))) begin
            cut_valid_next = 1'b1;
            cut_pos_next   = char_pos;
          end
        end
        M_OPEN: begin
          accum_next   = '0;
          stopped_next = 1'b0;
          if (tag_char == tms_pkg::CH_IDIOM) begin
            mode_next = M_I1;
          end else if (link_char) begin
            link_kind_next   = link_code;
            held_first_next  = '0;
            held_second_next = '0;
            mode_next        = M_L1;
          end else begin
            mode_next    = M_PLAIN;
            accum_next   = accum;
            stopped_next = stopped;
          end
        end
        default: begin
          if ((mode == M_I3 || mode == M_L3) && tag_char == tms_pkg::CH_LBRACKET) begin
            // third number ends; the bracket opens the next section
            if (mode == M_I3) begin
              idiom_next[2] = accum;
            end else begin
              push.count = 2'd1;
              push.first = link_res;
            end
            mode_next = M_OPEN;
          end else if (mode != M_I3 && mode != M_L3 && tag_char == tms_pkg::CH_DOT) begin
            unique case (mode)
              M_I1:    idiom_next[0]    = accum;
              M_I2:    idiom_next[1]    = accum;
              M_L1:    held_first_next  = accum;
              default: held_second_next = accum;
            endcase
            mode_next    = mode + 3'd1;
            accum_next   = '0;
            stopped_next = 1'b0;
          end else if (!stopped) begin
            if (is_digit) begin
              accum_next = (grown > {4'b0, NUM_MAX}) ? NUM_MAX : grown[NW-1:0];
            end else begin
              stopped_next = 1'b1;
            end
          end
        end
      endcase
    end

    if (!accept) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_PLAIN;
      accum       <= '0;
      stopped     <= 1'b0;
      held_first  <= '0;
      held_second <= '0;
      link_kind   <= '0;
      cut_valid   <= 1'b0;
      cut_pos     <= '0;
      char_pos    <= '0;
      idiom[0]    <= '0;
      idiom[1]    <= '0;
      idiom[2]    <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      accum       <= accum_next;
      stopped     <= stopped_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
      link_kind   <= link_kind_next;
      cut_valid   <= cut_valid_next;
      cut_pos     <= cut_pos_next;
      char_pos    <= char_pos_next;
      idiom       <= idiom_next;
    end
  end

  // terminator returns the scan to a fresh tag
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && tag_char == tms_pkg::CH_END) |=> (mode == M_PLAIN && char_pos == '0 && !cut_valid))
    else $error("tag state not cleared after terminator");

  // the cut never lies past the current position
  a_cut_order: assert property (@(posedge clk) disable iff (rst)
    cut_valid |-> (cut_pos <= char_pos))
    else $error("cut position beyond character position");

endmodule

FILE: sv/tms_queue.sv
// ----------------------------------------------------------------------------
// tms_queue: result queue
// Small register queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module tms_queue (
  input  logic               clk,
  input  logic               rst,
  input  tms_pkg::tms_push_t push,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output tms_pkg::tms_res_t  head
);

  localparam int AW = tms_pkg::QUEUE_AW;
  localparam int CW = tms_pkg::QUEUE_CW;

  tms_pkg::tms_res_t entry [tms_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;
  logic [AW-1:0] wr_ptr_1;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entry[rd_ptr];
  assign wr_ptr_1  = wr_ptr + AW'(1);
  // room for the worst case of two results
  assign space     = (count <= CW'(tms_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push.count) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(tms_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> space)
    else $error("push into queue without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) + CW'($past(push.count)) - CW'($past(pop))))
    else $error("queue count out of step");

endmodule

FILE: sv/tag_marker_stripper.sv
// ----------------------------------------------------------------------------
// tag_marker_stripper: semantic tag marker stripper
// Scans a tag one character per item, reports links and the kept length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel tag_valid/tag_ready/tag_char carries one character per item;
//   code 0 ends the tag. Output channel result_valid/result_ready carries one
//   result item: a link entry (result_kind 0) per opened "[m/a/s/h/d" link,
//   and a summary (result_kind 1, final_flag 1) on each terminator.
//   Configuration: cfg_write with cfg_index/cfg_data sets slash trimming
//   (index 0) and gender stripping (index 1); write only while idle.
// Timing:
//   The results of a character sit in the result queue the cycle after
//   acceptance. One character per cycle is sustained as long as results
//   are drained at one per cycle. A terminator that closes a link makes
//   two results, which leave the queue one at a time; the four-entry queue
//   absorbs that.
// Reset:
//   rst (synchronous) clears the scan state, the queue and both registers.
// Stall:
//   With result_ready low, results wait in the queue; tag_ready drops once
//   fewer than two free entries remain, and no result is ever dropped.
// ----------------------------------------------------------------------------
module tag_marker_stripper #(
  parameter int MAX_TAG_CHARS = tms_pkg::DEF_MAX_TAG_CHARS,
  parameter int NUMBER_WIDTH  = tms_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic                          cfg_data,
  // character input
  input  logic                          tag_valid,
  output logic                          tag_ready,
  input  logic [7:0]                    tag_char,
  // results
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          result_kind,
  output logic [tms_pkg::KIND_W-1:0]    link_kind,
  output logic [tms_pkg::FIELD_W-1:0]   link_first,
  output logic [tms_pkg::FIELD_W-1:0]   link_second,
  output logic [tms_pkg::FIELD_W-1:0]   link_third,
  output logic [tms_pkg::LEN_W-1:0]     kept_length,
  output logic [tms_pkg::FIELD_W-1:0]   idiom_first,
  output logic [tms_pkg::FIELD_W-1:0]   idiom_second,
  output logic [tms_pkg::FIELD_W-1:0]   idiom_third,
  output logic                          final_flag
);

  tms_pkg::tms_cfg_t  cfg;
  tms_pkg::tms_push_t push;
  tms_pkg::tms_res_t  head;
  logic               space;
  logic               accept;

  // hold the two mode bits; each write is registered at the clock edge
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tms_pkg::CFG_SLASH_TRIM:   cfg.slash_trim_enable   <= cfg_data;
        tms_pkg::CFG_GENDER_STRIP: cfg.gender_strip_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a character whenever the queue can hold its worst case
  assign tag_ready = space;
  assign accept    = tag_valid && tag_ready;

  tms_parse #(
    .MAX_TAG_CHARS (MAX_TAG_CHARS),
    .NUMBER_WIDTH  (NUMBER_WIDTH)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .tag_char (tag_char),
    .push     (push)
  );

  tms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .head      (head)
  );

  // drive result fields from the queue head
  assign result_kind  = head.result_kind;
  assign link_kind    = head.link_kind;
  assign link_first   = head.link_first;
  assign link_second  = head.link_second;
  assign link_third   = head.link_third;
  assign kept_length  = head.kept_length;
  assign idiom_first  = head.idiom_first;
  assign idiom_second = head.idiom_second;
  assign idiom_third  = head.idiom_third;
  assign final_flag   = head.final_flag;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tag marker stripper
// Streams semantic tags one character per item, with random gaps on both
// channels, predicts every link entry and end-of-tag summary in a local model
// of the scanner, and compares each result item field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_MAX     = (1 << tms_pkg::DEF_NUMBER_WIDTH) - 1;
  localparam int BLOCK_CHARS = 285;   // characters per random block
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STUCK_LIMIT = 2000;  // cycles with no handshake at all
  localparam int QUIET_TAIL  = 8;     // settle time before a register write

  typedef enum logic [3:0] {
    MODE_SCAN, MODE_OPEN,
    MODE_IDIOM1, MODE_IDIOM2, MODE_IDIOM3,
    MODE_LINK1, MODE_LINK2, MODE_LINK3
  } scan_mode_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, known from time zero
  logic       cfg_write    = 1'b0;
  logic       cfg_index    = tms_pkg::CFG_SLASH_TRIM;
  logic       cfg_data     = 1'b0;
  logic       tag_valid    = 1'b0;
  logic [7:0] tag_char     = tms_pkg::CH_END;
  logic       result_ready = 1'b0;

  // block outputs
  logic                        tag_ready;
  logic                        result_valid;
  logic                        result_kind;
  logic [tms_pkg::KIND_W-1:0]  link_kind;
  logic [tms_pkg::FIELD_W-1:0] link_first;
  logic [tms_pkg::FIELD_W-1:0] link_second;
  logic [tms_pkg::FIELD_W-1:0] link_third;
  logic [tms_pkg::LEN_W-1:0]   kept_length;
  logic [tms_pkg::FIELD_W-1:0] idiom_first;
  logic [tms_pkg::FIELD_W-1:0] idiom_second;
  logic [tms_pkg::FIELD_W-1:0] idiom_third;
  logic                        final_flag;

  // characters waiting to be offered, and results the scanner owes us
  logic [7:0]        tag_stream [$];
  tms_pkg::tms_res_t due_results [$];

  int chars_queued  = 0;
  int chars_taken   = 0;
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stuck         = 0;

  // local copy of the scanner: registers and per-tag state
  logic       slash_on  = 1'b0;
  logic       gender_on = 1'b0;
  scan_mode_t scan_mode;
  int         accum;
  bit         digits_done;
  int         held_a;
  int         held_b;
  logic [tms_pkg::KIND_W-1:0] link_code;
  bit         cut_seen;
  int         cut_at;
  int         char_count;
  int         idiom [3];

  tag_marker_stripper u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tag_valid    (tag_valid),
    .tag_ready    (tag_ready),
    .tag_char     (tag_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .link_kind    (link_kind),
    .link_first   (link_first),
    .link_second  (link_second),
    .link_third   (link_third),
    .kept_length  (kept_length),
    .idiom_first  (idiom_first),
    .idiom_second (idiom_second),
    .idiom_third  (idiom_third),
    .final_flag   (final_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------

  // Return every per-tag field to its idle value; registers are untouched.
  task automatic clear_scan();
    scan_mode   = MODE_SCAN;
    accum       = 0;
    digits_done = 1'b0;
    held_a      = 0;
    held_b      = 0;
    link_code   = tms_pkg::LINK_M;
    cut_seen    = 1'b0;
    cut_at      = 0;
    char_count  = 0;
    idiom[0]    = 0;
    idiom[1]    = 0;
    idiom[2]    = 0;
  endtask

  task automatic start_number();
    accum       = 0;
    digits_done = 1'b0;
  endtask

  // Leading digits only: the first non-digit freezes the number for the field.
  task automatic feed_digit(input logic [7:0] c);
    if (!digits_done) begin
      if (c >= tms_pkg::CH_DIGIT_LO && c <= tms_pkg::CH_DIGIT_HI) begin
        accum = accum * 10 + int'(c - tms_pkg::CH_DIGIT_LO);
        if (accum > NUM_MAX) accum = NUM_MAX;
      end else begin
        digits_done = 1'b1;
      end
    end
  endtask

  task automatic mark_cut();
    if (!cut_seen) begin
      cut_seen = 1'b1;
      cut_at   = char_count;
    end
  endtask

  task automatic push_link(input int a, input int b, input int c);
    tms_pkg::tms_res_t r;
    r             = '0;
    r.result_kind = tms_pkg::RESULT_LINK;
    r.link_kind   = link_code;
    r.link_first  = a[tms_pkg::FIELD_W-1:0];
    r.link_second = b[tms_pkg::FIELD_W-1:0];
    r.link_third  = c[tms_pkg::FIELD_W-1:0];
    due_results.push_back(r);
  endtask

  // Advance the model by one accepted character and queue what it emits.
  task automatic parse_tag_char(input logic [7:0] c);
    tms_pkg::tms_res_t r;
    int                len;
    if (c == tms_pkg::CH_END) begin
      // close whatever field is open, then summarize the tag
      case (scan_mode)
        MODE_LINK1:  push_link(accum, 0, 0);
        MODE_LINK2:  push_link(held_a, accum, 0);
        MODE_LINK3:  push_link(held_a, held_b, accum);
        MODE_IDIOM1: idiom[0] = accum;
        MODE_IDIOM2: idiom[1] = accum;
        MODE_IDIOM3: idiom[2] = accum;
        default: ;
      endcase
      len = cut_seen ? cut_at : char_count;
      if (len > tms_pkg::DEF_MAX_TAG_CHARS) len = tms_pkg::DEF_MAX_TAG_CHARS;
      r              = '0;
      r.result_kind  = tms_pkg::RESULT_SUMMARY;
      r.kept_length  = len[tms_pkg::LEN_W-1:0];
      r.idiom_first  = idiom[0][tms_pkg::FIELD_W-1:0];
      r.idiom_second = idiom[1][tms_pkg::FIELD_W-1:0];
      r.idiom_third  = idiom[2][tms_pkg::FIELD_W-1:0];
      r.final_flag   = 1'b1;
      due_results.push_back(r);
      clear_scan();
    end else begin
      case (scan_mode)
        MODE_SCAN: begin
          if (c == tms_pkg::CH_LBRACKET) begin
            mark_cut();
            scan_mode = MODE_OPEN;
          end else if (gender_on && c >= tms_pkg::CH_LOWER_LO
                       && c <= tms_pkg::CH_LOWER_HI) begin
            mark_cut();
          end else if (slash_on && c == tms_pkg::CH_SLASH) begin
            mark_cut();
          end else if (c == tms_pkg::CH_LBRACE) begin
            mark_cut();
          end
        end
        MODE_OPEN: begin
          scan_mode = MODE_LINK1;
          held_a    = 0;
          held_b    = 0;
          start_number();
          case (c)
            tms_pkg::CH_IDIOM:  scan_mode = MODE_IDIOM1;
            tms_pkg::CH_LINK_M: link_code = tms_pkg::LINK_M;
            tms_pkg::CH_LINK_A: link_code = tms_pkg::LINK_A;
            tms_pkg::CH_LINK_S: link_code = tms_pkg::LINK_S;
            tms_pkg::CH_LINK_H: link_code = tms_pkg::LINK_H;
            tms_pkg::CH_LINK_D: link_code = tms_pkg::LINK_D;
            default:            scan_mode = MODE_SCAN;   // unknown marker: drop it
          endcase
        end
        MODE_IDIOM1, MODE_IDIOM2, MODE_LINK1, MODE_LINK2: begin
          if (c == tms_pkg::CH_DOT) begin
            case (scan_mode)
              MODE_IDIOM1: begin idiom[0] = accum; scan_mode = MODE_IDIOM2; end
              MODE_IDIOM2: begin idiom[1] = accum; scan_mode = MODE_IDIOM3; end
              MODE_LINK1:  begin held_a = accum;   scan_mode = MODE_LINK2;  end
              default:     begin held_b = accum;   scan_mode = MODE_LINK3;  end
            endcase
            start_number();
          end else begin
            feed_digit(c);
          end
        end
        MODE_IDIOM3: begin
          // a bracket closes the third number and opens the next section
          if (c == tms_pkg::CH_LBRACKET) begin
            idiom[2]  = accum;
            scan_mode = MODE_OPEN;
          end else begin
            feed_digit(c);
          end
        end
        MODE_LINK3: begin
          if (c == tms_pkg::CH_LBRACKET) begin
            push_link(held_a, held_b, accum);
            scan_mode = MODE_OPEN;
          end else begin
            feed_digit(c);
          end
        end
        default: scan_mode = MODE_SCAN;
      endcase
      if (char_count < tms_pkg::DEF_MAX_TAG_CHARS) char_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders: everything lands in tag_stream
  // --------------------------------------------------------------------------

  task automatic put(input logic [7:0] c);
    tag_stream.push_back(c);
    chars_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) put(s[k]);
  endtask

  // Mostly short numbers, now and then long enough to saturate, and
  // occasionally trailing junk that stops the digits.
  task automatic queue_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
    for (int k = 0; k < n; k++) put(8'(tms_pkg::CH_DIGIT_LO + $urandom_range(0, 9)));
    if ($urandom_range(0, 7) == 0) put(8'("A" + $urandom_range(0, 25)));
  endtask

  task automatic queue_plain_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10)      put(8'("A" + $urandom_range(0, 25)));
    else if (r < 12) put(8'(tms_pkg::CH_DIGIT_LO + $urandom_range(0, 9)));
    else if (r < 15) put(8'(tms_pkg::CH_LOWER_LO + $urandom_range(0, 25)));
    else if (r < 17) put(tms_pkg::CH_SLASH);
    else if (r < 18) put(tms_pkg::CH_LBRACE);
    else if (r < 19) put(tms_pkg::CH_DOT);
    else             put(8'($urandom_range(1, 255)));
  endtask

  // One marker section; a truncated one stops part way and the tag ends there.
  task automatic queue_section(input bit truncate);
    logic [7:0] mark;
    int         pieces;
    case ($urandom_range(0, 7))
      0, 1:    mark = tms_pkg::CH_IDIOM;
      2:       mark = tms_pkg::CH_LINK_M;
      3:       mark = tms_pkg::CH_LINK_A;
      4:       mark = tms_pkg::CH_LINK_S;
      5:       mark = tms_pkg::CH_LINK_H;
      6:       mark = tms_pkg::CH_LINK_D;
      default: mark = 8'($urandom_range(1, 255));
    endcase
    pieces = truncate ? $urandom_range(0, 5) : 6;
    put(tms_pkg::CH_LBRACKET);
    for (int k = 1; k <= pieces; k++) begin
      case (k)
        1:       put(mark);
        3, 5:    put(tms_pkg::CH_DOT);
        default: queue_number();
      endcase
    end
  endtask

  task automatic queue_random_tag();
    int  style;
    int  n;
    bit  broken;
    style = $urandom_range(0, 99);
    if (style < 10) begin
      // raw noise: any nonzero byte
      n = $urandom_range(1, 80);
      for (int k = 0; k < n; k++) put(8'($urandom_range(1, 255)));
    end else begin
      broken = (style < 25);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 8);
      for (int k = 0; k < n; k++) queue_plain_char();
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
        // only the last section of a broken tag is cut short
        queue_section(broken && k == n - 1);
      end
    end
    put(tms_pkg::CH_END);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer one character per handshake, hold it until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      if (tag_valid && tag_ready) begin
        parse_tag_char(tag_char);
        chars_taken++;
      end
      // load a new item only when the current one is gone
      if (!tag_valid || tag_ready) begin
        if (tag_stream.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tag_valid <= 1'b1;
          tag_char  <= tag_stream.pop_front();
        end else begin
          tag_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result item against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    tms_pkg::tms_res_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing owed, result_kind", result_kind, 0);
    end else begin
      want = due_results.pop_front();
      if (result_kind !== want.result_kind)
        report_mismatch("result_kind", result_kind, want.result_kind);
      if (link_kind !== want.link_kind)
        report_mismatch("link_kind", link_kind, want.link_kind);
      if (link_first !== want.link_first)
        report_mismatch("link_first", link_first, want.link_first);
      if (link_second !== want.link_second)
        report_mismatch("link_second", link_second, want.link_second);
      if (link_third !== want.link_third)
        report_mismatch("link_third", link_third, want.link_third);
      if (kept_length !== want.kept_length)
        report_mismatch("kept_length", kept_length, want.kept_length);
      if (idiom_first !== want.idiom_first)
        report_mismatch("idiom_first", idiom_first, want.idiom_first);
      if (idiom_second !== want.idiom_second)
        report_mismatch("idiom_second", idiom_second, want.idiom_second);
      if (idiom_third !== want.idiom_third)
        report_mismatch("idiom_third", idiom_third, want.idiom_third);
      if (final_flag !== want.final_flag)
        report_mismatch("final_flag", final_flag, want.final_flag);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_result();
      // start a long hold-off when one is requested
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up when no item moves on either channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (tag_valid && tag_ready) || (result_valid && result_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles", stuck);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  // Wait until every queued character is taken and every result has come,
  // then let the block settle. The sender stays quiet while the block settles.
  task automatic wait_drained();
    while (chars_taken != chars_queued || due_results.size() != 0) @(posedge clk);
    repeat (QUIET_TAIL) @(posedge clk);
  endtask

  // Write both registers while the block is idle; update the model alongside.
  task automatic apply_config(input logic slash, input logic gender);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= tms_pkg::CFG_SLASH_TRIM;
    cfg_data  <= slash;
    slash_on   = slash;
    @(posedge clk);
    cfg_index <= tms_pkg::CFG_GENDER_STRIP;
    cfg_data  <= gender;
    gender_on  = gender;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int target;
    clear_scan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed tags, registers at their reset values
    apply_config(1'b0, 1'b0);
    send_idle_pct = 24;
    recv_idle_pct = 81;
    // idiom, then a link closed early by the terminator after junk
    queue_text("[i12.3.4[hx");
    put(tms_pkg::CH_END);
    // extreme bytes, unknown marker, then a bracket right before the end
    put(8'hFF);
    put(8'h01);
    queue_text("[q[");
    put(tms_pkg::CH_END);
    // brace cut at position zero, saturating link number, early end
    queue_text("{[s99999");
    put(tms_pkg::CH_END);

    // random blocks: rotate registers, walk through the idling patterns
    for (int blk = 0; blk < 6; blk++) begin
      wait_drained();
      case (blk)
        0: apply_config(1'b1, 1'b0);
        1: apply_config(1'b0, 1'b1);
        2: apply_config(1'b1, 1'b1);
        3: apply_config(1'b0, 1'b0);
        4: apply_config(1'b1, 1'b1);
        default: apply_config(1'b1, 1'b0);
      endcase
      if (blk < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 81;
      end else if (blk < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // starve the output while the sender keeps pushing, so the input stalls
      if (blk == 4) hold_requests++;
      target = chars_queued + BLOCK_CHARS;
      while (chars_queued < target) queue_random_tag();
    end

    wait_drained();
    if (due_results.size() != 0) report_mismatch("results never produced", 0,
                                                 due_results.size());
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
